[design/pos_pid_pkg.sv]
// Shared types and constants for the positional PID block with clamped integral.
// Used by every module under position_pid_clamped_integral. No dependencies.

package pos_pid_pkg;

   // Field and datapath widths
   localparam int POS_W      = 16;  // Q12.4 positions
   localparam int GAIN_W     = 16;  // Q8.8 gains
   localparam int ERR_W      = 17;  // target - measured
   localparam int DIFF_W     = 18;  // error - previous error
   localparam int INTEG_W    = 10;  // integral, always within +/-400
   localparam int ACC_W      = 18;  // integral + error before clamping
   localparam int PROD_P_W   = 33;  // kp * error
   localparam int PROD_I_W   = 26;  // ki * integral
   localparam int PROD_D_W   = 34;  // kd * difference
   localparam int RAW_W      = 36;  // exact sum, Q.12
   localparam int DRIVE_W    = 13;  // Q5.8 result
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Limits in their working formats
   localparam logic signed [RAW_W-1:0]   DRIVE_LIMIT_RAW = 36'sd36864; // 9.0 in Q.12
   localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT_Q8  = 13'sd2304;  // 9.0 in Q5.8
   localparam logic signed [ERR_W-1:0]   INTEGRATE_BELOW = 17'sd240;   // 15 in Q12.4
   localparam logic signed [ACC_W-1:0]   INTEGRAL_LIMIT  = 18'sd400;   // 25 in Q12.4

   // Register indexes (word address bits)
   localparam logic [1:0] CSR_GAIN_P = 2'd0;
   localparam logic [1:0] CSR_GAIN_I = 2'd1;
   localparam logic [1:0] CSR_GAIN_D = 2'd2;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kd;
   } gain_set_type;

   typedef struct packed {
      logic signed [PROD_P_W-1:0] prod_p;
      logic signed [PROD_I_W-1:0] prod_i;
      logic signed [PROD_D_W-1:0] prod_d;
   } product_set_type;

endpackage

[design/pos_pid_csr.sv]
// Gain register file behind an APB-style port.
// Depends on pos_pid_pkg for widths, register indexes and the gain struct.

module pos_pid_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pos_pid_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pos_pid_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pos_pid_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output pos_pid_pkg::gain_set_type             gains
);

   pos_pid_pkg::gain_set_type gains_ff;
   pos_pid_pkg::gain_set_type gains_in;
   logic                      wr_en;
   logic [1:0]                reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[3:2];

   // Write decode; unknown indexes are ignored
   always_comb begin
      gains_in = gains_ff;
      if (wr_en) begin
         unique case (reg_index)
            pos_pid_pkg::CSR_GAIN_P: gains_in.kp = csr_pwdata[pos_pid_pkg::GAIN_W-1:0];
            pos_pid_pkg::CSR_GAIN_I: gains_in.ki = csr_pwdata[pos_pid_pkg::GAIN_W-1:0];
            pos_pid_pkg::CSR_GAIN_D: gains_in.kd = csr_pwdata[pos_pid_pkg::GAIN_W-1:0];
            default:                 gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // Read mux, sign-extended to the bus width
   always_comb begin
      unique case (reg_index)
         pos_pid_pkg::CSR_GAIN_P: csr_prdata = pos_pid_pkg::CSR_DATA_W'(gains_ff.kp);
         pos_pid_pkg::CSR_GAIN_I: csr_prdata = pos_pid_pkg::CSR_DATA_W'(gains_ff.ki);
         pos_pid_pkg::CSR_GAIN_D: csr_prdata = pos_pid_pkg::CSR_DATA_W'(gains_ff.kd);
         default:                 csr_prdata = '0;
      endcase
   end

   assign gains = gains_ff;

endmodule

[design/pos_pid_mult.sv]
// Product stage: forms the error, the three gain products, and updates the
// clamped integral and previous error. Depends on pos_pid_pkg.

module pos_pid_mult (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pos_pid_pkg::gain_set_type               gains,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [pos_pid_pkg::POS_W-1:0]    in_target,
   input  logic signed [pos_pid_pkg::POS_W-1:0]    in_measured,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output pos_pid_pkg::product_set_type            out_products
);

   logic                                        valid_ff;
   logic                                        valid_in;
   pos_pid_pkg::product_set_type                products_ff;
   pos_pid_pkg::product_set_type                products_in;
   logic signed [pos_pid_pkg::INTEG_W-1:0]      integral_ff;
   logic signed [pos_pid_pkg::INTEG_W-1:0]      integral_in;
   logic signed [pos_pid_pkg::ERR_W-1:0]        prev_error_ff;
   logic signed [pos_pid_pkg::ERR_W-1:0]        prev_error_in;
   logic signed [pos_pid_pkg::ERR_W-1:0]        error;
   logic signed [pos_pid_pkg::DIFF_W-1:0]       diff;
   logic signed [pos_pid_pkg::ACC_W-1:0]        acc;
   logic                                        load;

   assign in_ready = ~valid_ff | out_ready;
   assign load     = in_valid & in_ready;

   // Error and derivative term
   assign error = pos_pid_pkg::ERR_W'(in_target) - pos_pid_pkg::ERR_W'(in_measured);
   assign diff  = pos_pid_pkg::DIFF_W'(error) - pos_pid_pkg::DIFF_W'(prev_error_ff);

   // Gain products, registered before the sum
   always_comb begin
      products_in.prod_p = pos_pid_pkg::PROD_P_W'(gains.kp) * pos_pid_pkg::PROD_P_W'(error);
      products_in.prod_i = pos_pid_pkg::PROD_I_W'(gains.ki) * pos_pid_pkg::PROD_I_W'(integral_ff);
      products_in.prod_d = pos_pid_pkg::PROD_D_W'(gains.kd) * pos_pid_pkg::PROD_D_W'(diff);
   end

   // One-sided integration, then clamp to +/-25
   always_comb begin
      acc = pos_pid_pkg::ACC_W'(integral_ff);
      if (error < pos_pid_pkg::INTEGRATE_BELOW) begin
         acc = pos_pid_pkg::ACC_W'(integral_ff) + pos_pid_pkg::ACC_W'(error);
      end
      if (acc > pos_pid_pkg::INTEGRAL_LIMIT) begin
         acc = pos_pid_pkg::INTEGRAL_LIMIT;
      end else if (acc < -pos_pid_pkg::INTEGRAL_LIMIT) begin
         acc = -pos_pid_pkg::INTEGRAL_LIMIT;
      end
   end

   // State advances only when an item moves into this stage
   always_comb begin
      valid_in      = valid_ff & ~out_ready;
      integral_in   = integral_ff;
      prev_error_in = prev_error_ff;
      if (load) begin
         valid_in      = 1'b1;
         integral_in   = acc[pos_pid_pkg::INTEG_W-1:0];
         prev_error_in = error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         integral_ff   <= '0;
         prev_error_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         integral_ff   <= integral_in;
         prev_error_ff <= prev_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         products_ff <= products_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_products = products_ff;

endmodule

[design/pos_pid_sat.sv]
// Output stage: sums the products, saturates to +/-9.0, converts to Q5.8
// and holds the result item. Depends on pos_pid_pkg.

module pos_pid_sat (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  pos_pid_pkg::product_set_type            in_products,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic signed [pos_pid_pkg::DRIVE_W-1:0]  out_drive,
   output logic                                    out_clipped
);

   logic                                        valid_ff;
   logic                                        valid_in;
   logic signed [pos_pid_pkg::DRIVE_W-1:0]      drive_ff;
   logic signed [pos_pid_pkg::DRIVE_W-1:0]      drive_in;
   logic                                        clipped_ff;
   logic                                        clipped_in;
   logic signed [pos_pid_pkg::RAW_W-1:0]        raw;
   logic signed [pos_pid_pkg::RAW_W-1:0]        raw_sat;
   logic                                        load;

   assign in_ready = ~valid_ff | out_ready;
   assign load     = in_valid & in_ready;

   // Exact sum of the three terms
   assign raw = pos_pid_pkg::RAW_W'(in_products.prod_p)
              + pos_pid_pkg::RAW_W'(in_products.prod_i)
              + pos_pid_pkg::RAW_W'(in_products.prod_d);

   // Saturate; exactly at the limit is not a clip
   always_comb begin
      raw_sat    = raw;
      clipped_in = 1'b0;
      if (raw > pos_pid_pkg::DRIVE_LIMIT_RAW) begin
         raw_sat    = pos_pid_pkg::DRIVE_LIMIT_RAW;
         clipped_in = 1'b1;
      end else if (raw < -pos_pid_pkg::DRIVE_LIMIT_RAW) begin
         raw_sat    = -pos_pid_pkg::DRIVE_LIMIT_RAW;
         clipped_in = 1'b1;
      end
   end

   // Floor to Q5.8: drop four fraction bits of the bounded value
   assign drive_in = raw_sat[pos_pid_pkg::DRIVE_W+3:4];

   assign valid_in = load | (valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff   <= drive_in;
         clipped_ff <= clipped_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_drive   = drive_ff;
   assign out_clipped = clipped_ff;

endmodule

[design/position_pid_clamped_integral.sv]
// Positional PID for one axis with a one-sided, clamped integral.
// Each accepted item passes the input register, then the product register, then the
// result register, which holds the result. Throughput: one item per cycle; each
// stage holds while the next is full and stalled, so the rate is set by rsp_ready alone.
// Reset (synchronous): gains, integral, previous error and all valid flags clear.
// Depends on pos_pid_pkg, pos_pid_csr, pos_pid_mult and pos_pid_sat.

module position_pid_clamped_integral (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [pos_pid_pkg::POS_W-1:0]    req_target_position,
   input  logic signed [pos_pid_pkg::POS_W-1:0]    req_measured_position,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pos_pid_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic                                    rsp_clipped,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [pos_pid_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pos_pid_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pos_pid_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                    csr_pready
);

   pos_pid_pkg::gain_set_type                   gains;
   pos_pid_pkg::product_set_type                products;
   logic                                        s0_valid_ff;
   logic                                        s0_valid_in;
   logic signed [pos_pid_pkg::POS_W-1:0]        s0_target_ff;
   logic signed [pos_pid_pkg::POS_W-1:0]        s0_measured_ff;
   logic                                        s0_load;
   logic                                        mult_ready;
   logic                                        mult_valid;
   logic                                        sat_ready;

   // Gain registers
   pos_pid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   // Input register
   assign req_ready   = ~s0_valid_ff | mult_ready;
   assign s0_load     = req_valid & req_ready;
   assign s0_valid_in = s0_load | (s0_valid_ff & ~mult_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_target_ff   <= req_target_position;
         s0_measured_ff <= req_measured_position;
      end
   end

   // Error, products and state update
   pos_pid_mult u_mult (
      .clock        (clock),
      .reset        (reset),
      .gains        (gains),
      .in_valid     (s0_valid_ff),
      .in_ready     (mult_ready),
      .in_target    (s0_target_ff),
      .in_measured  (s0_measured_ff),
      .out_valid    (mult_valid),
      .out_ready    (sat_ready),
      .out_products (products)
   );

   // Sum, saturation and result register
   pos_pid_sat u_sat (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mult_valid),
      .in_ready    (sat_ready),
      .in_products (products),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_drive   (rsp_drive),
      .out_clipped (rsp_clipped)
   );

`ifndef SYNTHESIS
   // Drive never leaves +/-9.0
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= pos_pid_pkg::DRIVE_LIMIT_Q8) &&
                    (rsp_drive >= -pos_pid_pkg::DRIVE_LIMIT_Q8))
      else $error("drive outside saturation limit");

   // A clipped result sits exactly at one of the limits
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |-> (rsp_drive == pos_pid_pkg::DRIVE_LIMIT_Q8) ||
                                     (rsp_drive == -pos_pid_pkg::DRIVE_LIMIT_Q8))
      else $error("clip flag set with drive inside limits");

   // An item in the input register that cannot advance is kept
   a_s0_hold: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && !mult_ready) |=> s0_valid_ff && $stable(s0_target_ff) &&
                                       $stable(s0_measured_ff))
      else $error("input register lost a stalled item");
`endif

endmodule
